// ===== sv/button_gesture_classifier_defines.svh =====
// Assertion macros used by the button gesture classifier core.
`ifndef BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bgc_pkg.sv =====
// Types and constants of the button gesture classifier.
package bgc_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned MsW   = 16;
  localparam int unsigned TimeW = 32;

  // Register indexes (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_MIN_PRESS = 2'd0,
    REG_MAX_SHORT = 2'd1,
    REG_GAP       = 2'd2,
    REG_LONG      = 2'd3
  } reg_idx_t;

  localparam logic [MsW-1:0] MinPressRst = 16'd50;
  localparam logic [MsW-1:0] MaxShortRst = 16'd500;
  localparam logic [MsW-1:0] GapRst      = 16'd500;
  localparam logic [MsW-1:0] LongRst     = 16'd2000;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_RSVD   = 2'd3
  } gesture_t;

  typedef struct packed {
    logic [MsW-1:0] min_press_ms;
    logic [MsW-1:0] max_short_ms;
    logic [MsW-1:0] gap_ms;
    logic [MsW-1:0] long_ms;
  } cfg_t;

  typedef struct packed {
    logic             button_level;
    logic [TimeW-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0] gesture;
    logic       long_press;
  } out_t;

endpackage

// ===== sv/button_gesture_classifier.sv =====
// Top level of the button gesture classifier: input stage, core and result register.
// One item (a button pin sample with its millisecond time) gives exactly one result
// item: a flushed single or double press gesture and a one-shot long-press flag. Items
// are taken every cycle while in_ready is high; each item passes through one input
// register, then the classification logic into the result register, and the state
// updates in the same cycle as the result is written, so the next item sees it.
// in_ready drops only while both the input register and the result register are full
// and out_ready is low. Registers: min_press_ms at 0x0, max_short_ms at 0x4, gap_ms at
// 0x8, long_ms at 0xC, 16 bits each; write them only while no item is in flight.
module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  in_t  s1_data_r;
  logic s1_vld_r, s1_vld_nxt;
  out_t out_data_r;
  logic out_vld_r, out_vld_nxt;
  logic out_free, advance, in_acc;
  out_t res;

  bgc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bgc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_free = !out_vld_r || out_ready;
  assign advance  = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;
  assign in_acc   = in_valid && in_ready;

  assign s1_vld_nxt  = in_acc || (s1_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && !out_ready);

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: load on accept / advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== sv/bgc_regs.sv =====
// APB-style configuration registers of the button gesture classifier.
module bgc_regs
  import bgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MIN_PRESS: cfg_nxt.min_press_ms = pwdata[MsW-1:0];
        REG_MAX_SHORT: cfg_nxt.max_short_ms = pwdata[MsW-1:0];
        REG_GAP:       cfg_nxt.gap_ms       = pwdata[MsW-1:0];
        REG_LONG:      cfg_nxt.long_ms      = pwdata[MsW-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_PRESS: prdata = {{(DataW-MsW){1'b0}}, cfg_r.min_press_ms};
      REG_MAX_SHORT: prdata = {{(DataW-MsW){1'b0}}, cfg_r.max_short_ms};
      REG_GAP:       prdata = {{(DataW-MsW){1'b0}}, cfg_r.gap_ms};
      REG_LONG:      prdata = {{(DataW-MsW){1'b0}}, cfg_r.long_ms};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_press_ms <= MinPressRst;
      cfg_r.max_short_ms <= MaxShortRst;
      cfg_r.gap_ms       <= GapRst;
      cfg_r.long_ms      <= LongRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== sv/bgc_core.sv =====
// Edge, hold and click-count logic with the per-button state registers.
module bgc_core
  import bgc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t res
);

`include "button_gesture_classifier_defines.svh"

  logic             prev_level_r, prev_level_nxt;
  logic [TimeW-1:0] press_time_r, press_time_nxt;
  logic             long_seen_r, long_seen_nxt;
  logic [1:0]       click_count_r, click_count_nxt;
  logic [TimeW-1:0] release_time_r, release_time_nxt;

  logic             press_edge, rel_edge, held;
  logic [TimeW-1:0] dur, gap;
  logic             short_hit, long_hit, flush;
  logic [1:0]       cnt_inc;

  // Wide elapsed time against a 16-bit threshold.
  function automatic logic gt_ms(input logic [TimeW-1:0] d, input logic [MsW-1:0] t);
    gt_ms = (|d[TimeW-1:MsW]) || (d[MsW-1:0] > t);
  endfunction

  function automatic logic lt_ms(input logic [TimeW-1:0] d, input logic [MsW-1:0] t);
    lt_ms = !(|d[TimeW-1:MsW]) && (d[MsW-1:0] < t);
  endfunction

  assign press_edge = !item.button_level && prev_level_r;
  assign rel_edge   = item.button_level && !prev_level_r;
  assign held       = !item.button_level && !prev_level_r;

  assign dur = item.now_ms - press_time_r;
  assign gap = item.now_ms - release_time_r;

  assign short_hit = rel_edge && gt_ms(dur, cfg.min_press_ms) &&
                     lt_ms(dur, cfg.max_short_ms) && !long_seen_r;
  assign long_hit  = held && gt_ms(dur, cfg.long_ms) && !long_seen_r;

  // Saturate at three.
  assign cnt_inc = (short_hit && (click_count_r != 2'd3)) ? click_count_r + 2'd1
                                                          : click_count_r;

  // A release counted this step restarts the gap and blocks a flush in the same step.
  assign flush = (cnt_inc != 2'd0) && !short_hit && gt_ms(gap, cfg.gap_ms);

  always_comb begin
    res.long_press = long_hit;
    res.gesture    = GEST_NONE;
    if (flush) begin
      priority if (cnt_inc == 2'd1) begin
        res.gesture = GEST_SINGLE;
      end else if (cnt_inc == 2'd2) begin
        res.gesture = GEST_DOUBLE;
      end else begin
        res.gesture = GEST_NONE;
      end
    end
  end

  always_comb begin
    prev_level_nxt   = item.button_level;
    press_time_nxt   = press_edge ? item.now_ms : press_time_r;
    release_time_nxt = short_hit ? item.now_ms : release_time_r;
    click_count_nxt  = flush ? 2'd0 : cnt_inc;
    long_seen_nxt    = long_seen_r;
    if (press_edge) begin
      long_seen_nxt = 1'b0;
    end else if (long_hit) begin
      long_seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r   <= 1'b1;
      press_time_r   <= '0;
      long_seen_r    <= 1'b0;
      click_count_r  <= 2'd0;
      release_time_r <= '0;
    end else if (step) begin
      prev_level_r   <= prev_level_nxt;
      press_time_r   <= press_time_nxt;
      long_seen_r    <= long_seen_nxt;
      click_count_r  <= click_count_nxt;
      release_time_r <= release_time_nxt;
    end
  end

  `BGC_ASSERT_NEXT(a_long_once, clk, rst_n, step && res.long_press,
                   long_seen_r, "long press without long_seen set")
  `BGC_ASSERT_NEXT(a_flush_clears, clk, rst_n, step && (res.gesture != GEST_NONE),
                   click_count_r == 2'd0, "count not cleared after gesture")
  `BGC_ASSERT_NEXT(a_saturate, clk, rst_n, step && short_hit && (click_count_r == 2'd3),
                   click_count_r == 2'd3, "click count wrapped")
  `BGC_ASSERT_NOW(a_no_both, clk, rst_n, step, !(short_hit && long_hit),
                  "short and long press in one step")

endmodule
